// File: design/upi_pkg.sv
// Shared types, constants and the arctangent table for the unicycle pose integrator.
package upi_pkg;

  localparam int ATAN_ENTRIES = 24;
  localparam int STEP_W       = 5;

  // Start value of the rotation: 1/K of the CORDIC gain, Q2.30
  localparam logic signed [32:0] CORDIC_GAIN_Q30 = 33'sd652032874;

  // 65536/(2*pi) in Q16.16, split into a high and a low 16-bit half
  localparam logic signed [17:0] RAD2BAM_HI = 18'sd10430;
  localparam logic signed [17:0] RAD2BAM_LO = 18'sd24796;

  localparam logic [2:0] REG_MODE       = 3'd0;
  localparam logic [2:0] REG_TIME_STEP  = 3'd1;
  localparam logic [2:0] REG_START_X    = 3'd2;
  localparam logic [2:0] REG_START_Y    = 3'd3;
  localparam logic [2:0] REG_START_HEAD = 3'd4;
  localparam logic [2:0] REG_START_V    = 3'd5;
  localparam logic [2:0] REG_START_W    = 3'd6;

  localparam logic ACT_STEP    = 1'b0;
  localparam logic ACT_RESTART = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIST,
    S_TURN,
    S_ROT,
    S_XH,
    S_XL,
    S_XA,
    S_YH,
    S_YL,
    S_YA,
    S_HH,
    S_HL,
    S_HA,
    S_OUT
  } state_t;

  // atan(2^-i), 2^32 per turn
  function automatic logic signed [31:0] atan_lut(input logic [STEP_W-1:0] idx);
    logic signed [31:0] r;
    case (idx)
      5'd0:    r = 32'sd536870912;
      5'd1:    r = 32'sd316933406;
      5'd2:    r = 32'sd167458907;
      5'd3:    r = 32'sd85004756;
      5'd4:    r = 32'sd42667331;
      5'd5:    r = 32'sd21354465;
      5'd6:    r = 32'sd10679838;
      5'd7:    r = 32'sd5340245;
      5'd8:    r = 32'sd2670163;
      5'd9:    r = 32'sd1335087;
      5'd10:   r = 32'sd667544;
      5'd11:   r = 32'sd333772;
      5'd12:   r = 32'sd166886;
      5'd13:   r = 32'sd83443;
      5'd14:   r = 32'sd41722;
      5'd15:   r = 32'sd20861;
      5'd16:   r = 32'sd10430;
      5'd17:   r = 32'sd5215;
      5'd18:   r = 32'sd2608;
      5'd19:   r = 32'sd1304;
      5'd20:   r = 32'sd652;
      5'd21:   r = 32'sd326;
      5'd22:   r = 32'sd163;
      5'd23:   r = 32'sd81;
      default: r = 32'sd0;
    endcase
    return r;
  endfunction

endpackage

// File: design/unicycle_pose_integrator_top.sv
// Top level of the unicycle pose integrator: sequencer, shared multiplier and pose state.
//
// Channels: an input channel (in_valid/in_ready) carries action, linear_speed and
// turn_rate; a result channel (out_valid/out_ready) returns pos_x, pos_y, heading and
// saturated, one result per input item. A configuration channel (cfg_valid/cfg_ready,
// cfg_index, cfg_data) writes the mode, time step and start registers; it is always
// ready and unknown indexes are dropped.
// Timing: a step item forms the speed products while the CORDIC loop runs
// (one micro-rotation per cycle, CORDIC_STEPS capped at 24), then makes six passes
// through one 34x18 multiplier with a 66-bit accumulator and three pose updates
// before its result is valid. A restart item has its result valid the cycle after the
// transfer. One item is in flight at a time; in_ready is low from transfer until the
// cycle after the result is taken, so a new item is taken only after the last result
// has been taken.
// Reset: registers take their listed reset values, the pose and the previous
// speeds clear to zero and the block comes up ready.
// Stall: a result holds on the output ports until out_ready is seen; no new
// item is taken meanwhile.
module unicycle_pose_integrator_top #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               action,
  input  logic signed [15:0] linear_speed,
  input  logic signed [15:0] turn_rate,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic [15:0]        heading,
  output logic               saturated,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import upi_pkg::*;

  state_t state;
  state_t state_next;

  // configuration
  logic               integration_mode;
  logic [15:0]        time_step;
  logic signed [31:0] start_pos_x;
  logic signed [31:0] start_pos_y;
  logic [15:0]        start_heading;
  logic signed [15:0] start_speed;
  logic signed [15:0] start_turn_rate;

  // pose state
  logic signed [31:0] pose_x;
  logic signed [31:0] pose_y;
  logic [15:0]        pose_heading;
  logic signed [15:0] prev_speed;
  logic signed [15:0] prev_turn_rate;
  logic               sat;

  // working registers
  logic signed [16:0] sv;
  logic signed [16:0] sw;
  logic signed [32:0] travel;
  logic signed [32:0] tdist;
  logic signed [65:0] acc;

  logic signed [16:0] sv_next;
  logic signed [16:0] sw_next;

  // shared multiplier
  logic signed [33:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [51:0] prod;
  logic signed [65:0] mac;
  logic               acc_shift;

  logic               accept;
  logic               cordic_start;
  logic               cordic_done;
  logic signed [32:0] cos_v;
  logic signed [32:0] sin_v;

  // rounding and pose update
  logic signed [65:0] rnd;
  logic signed [26:0] dpos;
  logic signed [31:0] pos_old;
  logic signed [33:0] pos_sum;
  logic signed [31:0] pos_clip;
  logic               pos_sat;
  logic [15:0]        dh;

  upi_cordic #(
    .STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk    (clk),
    .rst    (rst),
    .start  (cordic_start),
    .angle  (pose_heading),
    .done   (cordic_done),
    .cos_out(cos_v),
    .sin_out(sin_v)
  );

  assign cfg_ready = 1'b1;
  assign accept    = in_valid & in_ready;

  assign sv_next = integration_mode ? (17'(linear_speed) + 17'(prev_speed))
                                    : (17'(linear_speed) <<< 1);
  assign sw_next = integration_mode ? (17'(turn_rate) + 17'(prev_turn_rate))
                                    : (17'(turn_rate) <<< 1);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = (action == ACT_RESTART) ? S_OUT : S_DIST;
        end
      end
      S_DIST: state_next = S_TURN;
      S_TURN: state_next = S_ROT;
      S_ROT: begin
        if (cordic_done) begin
          state_next = S_XH;
        end
      end
      S_XH:   state_next = S_XL;
      S_XL:   state_next = S_XA;
      S_XA:   state_next = S_YH;
      S_YH:   state_next = S_YL;
      S_YL:   state_next = S_YA;
      S_YA:   state_next = S_HH;
      S_HH:   state_next = S_HL;
      S_HL:   state_next = S_HA;
      S_HA:   state_next = S_OUT;
      S_OUT: begin
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs and multiplier operand selection
  always_comb begin
    in_ready     = 1'b0;
    out_valid    = 1'b0;
    cordic_start = 1'b0;
    acc_shift    = 1'b0;
    mul_a        = 34'(travel);
    mul_b        = '0;
    unique case (state)
      S_IDLE: begin
        in_ready     = 1'b1;
        cordic_start = in_valid & (action == ACT_STEP);
      end
      S_DIST: begin
        mul_a = 34'(sv);
        mul_b = $signed({2'b00, time_step});
      end
      S_TURN: begin
        mul_a = 34'(sw);
        mul_b = $signed({2'b00, time_step});
      end
      S_XH: begin
        mul_b = 18'($signed(cos_v[32:16]));
      end
      S_XL: begin
        mul_b     = $signed({2'b00, cos_v[15:0]});
        acc_shift = 1'b1;
      end
      S_YH: begin
        mul_b = 18'($signed(sin_v[32:16]));
      end
      S_YL: begin
        mul_b     = $signed({2'b00, sin_v[15:0]});
        acc_shift = 1'b1;
      end
      S_HH: begin
        mul_a = 34'(tdist);
        mul_b = RAD2BAM_HI;
      end
      S_HL: begin
        mul_a     = 34'(tdist);
        mul_b     = RAD2BAM_LO;
        acc_shift = 1'b1;
      end
      S_OUT: begin
        out_valid = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign prod = mul_a * mul_b;
  assign mac  = acc_shift ? ((acc <<< 16) + 66'(prod)) : 66'(prod);

  // position: round half up at bit 39, then clip to 32 bits
  assign rnd      = acc + (66'sd1 <<< 38);
  assign dpos     = rnd[65:39];
  assign pos_old  = (state == S_YA) ? pose_y : pose_x;
  assign pos_sum  = 34'(pos_old) + 34'(dpos);
  assign pos_sat  = (pos_sum[33:31] != 3'b000) && (pos_sum[33:31] != 3'b111);
  assign pos_clip = pos_sat ? (pos_sum[33] ? 32'sh8000_0000 : 32'sh7fff_ffff)
                            : pos_sum[31:0];
  // heading: round half up at bit 41, keep 16 wrapping bits
  assign dh       = 16'(((acc + (66'sd1 <<< 40)) >>> 41));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integration_mode <= 1'b0;
      time_step        <= 16'd655;
      start_pos_x      <= '0;
      start_pos_y      <= '0;
      start_heading    <= '0;
      start_speed      <= '0;
      start_turn_rate  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MODE:       integration_mode <= cfg_data[0];
        REG_TIME_STEP:  time_step        <= cfg_data[15:0];
        REG_START_X:    start_pos_x      <= cfg_data;
        REG_START_Y:    start_pos_y      <= cfg_data;
        REG_START_HEAD: start_heading    <= cfg_data[15:0];
        REG_START_V:    start_speed      <= cfg_data[15:0];
        REG_START_W:    start_turn_rate  <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pose_x         <= '0;
      pose_y         <= '0;
      pose_heading   <= '0;
      prev_speed     <= '0;
      prev_turn_rate <= '0;
      sat            <= 1'b0;
    end else if (accept) begin
      sat <= 1'b0;
      if (action == ACT_RESTART) begin
        pose_x         <= start_pos_x;
        pose_y         <= start_pos_y;
        pose_heading   <= start_heading;
        prev_speed     <= start_speed;
        prev_turn_rate <= start_turn_rate;
      end else begin
        prev_speed     <= linear_speed;
        prev_turn_rate <= turn_rate;
      end
    end else if (state == S_XA) begin
      pose_x <= pos_clip;
      sat    <= sat | pos_sat;
    end else if (state == S_YA) begin
      pose_y <= pos_clip;
      sat    <= sat | pos_sat;
    end else if (state == S_HA) begin
      pose_heading <= pose_heading + dh;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sv <= sv_next;
      sw <= sw_next;
    end
    if (state == S_DIST) begin
      travel <= prod[32:0];
    end
    if (state == S_TURN) begin
      tdist <= prod[32:0];
    end
    acc <= mac;
  end

  assign pos_x     = pose_x;
  assign pos_y     = pose_y;
  assign heading   = pose_heading;
  assign saturated = sat;

endmodule

// File: design/upi_cordic.sv
// Iterative rotation-mode CORDIC: one micro-rotation per cycle, gives cos and sin in Q2.30.
module upi_cordic #(
  parameter int STEPS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [15:0]        angle,
  output logic               done,
  output logic signed [32:0] cos_out,
  output logic signed [32:0] sin_out
);
  import upi_pkg::*;

  localparam int NUM = (STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : STEPS;
  localparam logic [STEP_W-1:0] LAST = STEP_W'(NUM - 1);

  logic                busy;
  logic [STEP_W-1:0]   cnt;
  logic signed [32:0]  x;
  logic signed [32:0]  y;
  logic signed [31:0]  z;
  logic                flip;

  logic signed [32:0]  xs;
  logic signed [32:0]  ys;
  logic signed [31:0]  step_angle;
  logic                fold;

  assign xs         = x >>> cnt;
  assign ys         = y >>> cnt;
  assign step_angle = atan_lut(cnt);
  // headings in the back half-plane get a half-turn shift and a sign flip
  assign fold       = angle[14] ^ angle[15];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == LAST) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x    <= CORDIC_GAIN_Q30;
      y    <= '0;
      z    <= $signed({angle[15] ^ fold, angle[14:0], 16'h0000});
      flip <= fold;
    end else if (busy) begin
      if (!z[31]) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - step_angle;
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + step_angle;
      end
    end
  end

  assign done    = ~busy;
  assign cos_out = flip ? -x : x;
  assign sin_out = flip ? -y : y;

endmodule
